// ===== hdl/firs_pkg.sv =====
// ----------------------------------------------------------------------------
// FIR filter stream package
// Shared types and fixed field widths of the streaming FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package firs_pkg;

    localparam int VALUE_W   = 16;
    localparam int SLOT_W    = 5;
    localparam int CFG_W     = 6;
    localparam int FRAC_BITS = 15;
    localparam int TAP_RESET = 32;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam int SLOT_LSB  = 0;
    localparam int VALUE_LSB = SLOT_LSB + SLOT_W;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic                      saturated;
        logic signed [VALUE_W-1:0] filtered_value;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/fir_filter_stream_unit.sv =====
// ----------------------------------------------------------------------------
// FIR filter stream unit
// Direct-form FIR filter on Q1.15 samples with a loadable coefficient table.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel. tuser selects the kind: a push item
// shifts a sample into the delay line, a load item writes one coefficient.
// tlast on a push item ends a block; the next result then needs tap_count
// fresh samples. Results leave on the m_axis channel, value in tdata and the
// saturation flag in tuser. The cfg channel writes tap_count and is always
// ready; the user must write it only while no item is in flight, and the
// block itself does not enforce this. One item is accepted per cycle while
// s_axis_tready is high. For each result the window is aligned to the tap
// count and registered, all taps are multiplied in parallel, a registered
// adder tree sums the products by level, and the sum enters the output queue.
// Results wait in an output queue; s_axis_tready drops only when every queue
// slot is claimed by a pending result, so a stalled receiver holds the input
// back after that many results and no result is lost.
// Reset clears the coefficient table to zero, the fill count, the queue and
// sets tap_count to 32. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_stream_unit #(
    parameter int MAX_TAPS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [4:0] coeff_index, [20:5] value, [23:21] zero
    input  wire logic [firs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  wire logic [0:0]                        s_axis_tuser,
    input  wire logic                              s_axis_tlast,

    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] filtered_value
    output      logic [firs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] saturated
    output      logic [0:0]                        m_axis_tuser,

    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [firs_pkg::CFG_W-1:0]        cfg_data
);

    localparam int VW  = firs_pkg::VALUE_W;
    localparam int IW  = $clog2(MAX_TAPS);
    localparam int TW  = ($clog2(MAX_TAPS + 1) > firs_pkg::CFG_W) ?
                         $clog2(MAX_TAPS + 1) : firs_pkg::CFG_W;
    localparam int SW  = (IW > firs_pkg::SLOT_W) ? IW : firs_pkg::SLOT_W;
    localparam int VSH = $clog2(VW);
    localparam int NP  = 1 << IW;
    localparam int AW  = 2 * VW + IW;
    localparam int NV  = IW + 3;
    localparam int FD  = 1 << $clog2(IW + 6);
    localparam int FW  = $clog2(FD);
    localparam int FB  = firs_pkg::FRAC_BITS;

    logic                            s_acc;
    logic                            m_acc;
    firs_pkg::op_t                   in_op;
    logic [firs_pkg::SLOT_W-1:0]     in_slot;
    logic signed [VW-1:0]            in_value;
    logic [SW-1:0]                   slot_w;
    logic                            slot_ok;

    logic [firs_pkg::CFG_W-1:0]      tap_reg;
    logic [TW-1:0]                   tap_ext;
    logic [TW-1:0]                   t_eff;
    logic [TW-1:0]                   fill_reg;
    logic [TW-1:0]                   fill_inc;
    logic [TW-1:0]                   fill_next;
    logic                            emit;

    logic [MAX_TAPS*VW-1:0]          win_reg;
    logic [MAX_TAPS*VW-1:0]          win_aligned;
    logic [TW-1:0]                   sh_amt;
    logic signed [VW-1:0]            coef_reg [MAX_TAPS];

    logic signed [VW-1:0]            s1_x_reg [MAX_TAPS];
    logic signed [VW-1:0]            s1_h_reg [MAX_TAPS];
    logic signed [AW-1:0]            tree_reg [2*NP-1];
    logic [NV-1:0]                   vld_reg;

    logic [AW-FB-1:0]                q_hi;
    logic                            q_sat;
    firs_pkg::result_t               res;

    firs_pkg::result_t               fifo_reg [FD];
    logic [FW-1:0]                   wr_ptr_reg;
    logic [FW-1:0]                   rd_ptr_reg;
    logic [FW:0]                     cnt_reg;
    logic [FW:0]                     cred_reg;
    logic [FW:0]                     cred_next;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign in_op    = firs_pkg::op_t'(s_axis_tuser[0]);
    assign in_slot  = s_axis_tdata[firs_pkg::SLOT_LSB +: firs_pkg::SLOT_W];
    assign in_value = s_axis_tdata[firs_pkg::VALUE_LSB +: VW];
    assign slot_w   = SW'(in_slot);
    assign slot_ok  = TW'(in_slot) < TW'(MAX_TAPS);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        tap_ext = TW'(tap_reg);
        if (tap_ext == '0)
        begin
            t_eff = TW'(1);
        end
        else if (tap_ext > TW'(MAX_TAPS))
        begin
            t_eff = TW'(MAX_TAPS);
        end
        else
        begin
            t_eff = tap_ext;
        end
        fill_inc  = (fill_reg < t_eff) ? fill_reg + TW'(1) : fill_reg;
        emit      = (in_op == firs_pkg::OP_PUSH) && (fill_inc >= t_eff);
        fill_next = s_axis_tlast ? '0 : fill_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= firs_pkg::CFG_W'(firs_pkg::TAP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (s_acc)
        begin
            if (in_op == firs_pkg::OP_PUSH)
            begin
                fill_reg <= fill_next;
            end
            else if (slot_ok)
            begin
                coef_reg[slot_w[IW-1:0]] <= in_value;
            end
        end
    end

    // The newest sample sits in the top lane; lane 0 holds the oldest.
    always_ff @(posedge clk)
    begin
        if (s_acc && (in_op == firs_pkg::OP_PUSH))
        begin
            win_reg <= {in_value, win_reg[MAX_TAPS*VW-1:VW]};
        end
    end

    assign sh_amt      = TW'(MAX_TAPS) - t_eff;
    assign win_aligned = win_reg >> {sh_amt, {VSH{1'b0}}};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            s1_x_reg[i] <= win_aligned[i*VW +: VW];
            s1_h_reg[i] <= coef_reg[i];
        end
        for (int i = 0; i < NP; i++)
        begin
            if (i < MAX_TAPS)
            begin
                tree_reg[NP-1+i] <= AW'(s1_x_reg[i] * s1_h_reg[i]);
            end
            else
            begin
                tree_reg[NP-1+i] <= '0;
            end
        end
        for (int k = 0; k < NP - 1; k++)
        begin
            tree_reg[k] <= tree_reg[2*k+1] + tree_reg[2*k+2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NV-2:0], s_acc && emit};
        end
    end

    always_comb
    begin
        q_hi  = tree_reg[0][AW-1:FB];
        q_sat = !((&q_hi[AW-FB-1:VW-1]) || !(|q_hi[AW-FB-1:VW-1]));
        res.saturated = q_sat;
        if (q_sat)
        begin
            res.filtered_value = q_hi[AW-FB-1] ? firs_pkg::VALUE_MIN : firs_pkg::VALUE_MAX;
        end
        else
        begin
            res.filtered_value = q_hi[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[NV-1])
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    always_comb
    begin
        cred_next = cred_reg;
        if (s_acc && emit)
        begin
            cred_next = cred_next + (FW+1)'(1);
        end
        if (m_acc)
        begin
            cred_next = cred_next - (FW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            cred_reg   <= '0;
        end
        else
        begin
            cred_reg <= cred_next;
            if (vld_reg[NV-1])
            begin
                wr_ptr_reg <= wr_ptr_reg + FW'(1);
            end
            if (m_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + FW'(1);
            end
            case ({vld_reg[NV-1], m_acc})
                2'b10:   cnt_reg <= cnt_reg + (FW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (FW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign s_axis_tready = cred_reg < (FW+1)'(FD);
    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = fifo_reg[rd_ptr_reg].filtered_value;
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].saturated;

endmodule

`default_nettype wire

// ===== hdl/firs_checker.sv =====
// ----------------------------------------------------------------------------
// FIR filter stream checker
// Port-level assertions for the streaming FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module firs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [firs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic [0:0]                        m_axis_tuser
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result item changed or was dropped.");

    a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata == firs_pkg::VALUE_MAX) || (m_axis_tdata == firs_pkg::VALUE_MIN))
        else $error("Saturated result item is not a range limit.");

    a_ready_drop : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("Input ready dropped without an accepted item.");

endmodule

bind fir_filter_stream_unit firs_checker u_firs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Streaming FIR filter testbench
// Drives sample and coefficient items into the filter and checks every output
// against a built-in direct-form model. The run covers directed corner cases,
// many random tap settings with random blocks, long output backpressure, and
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int TAPS        = 32;
    localparam int LATENCY     = 12;
    localparam int LONG_HOLD   = 400;

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [firs_pkg::IN_DATA_W-1:0]      s_axis_tdata;
    logic [0:0]                          s_axis_tuser;
    logic                                s_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [firs_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic [0:0]                          m_axis_tuser;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [firs_pkg::CFG_W-1:0]          cfg_data;

    logic signed [firs_pkg::VALUE_W-1:0] window_m [TAPS];
    logic signed [firs_pkg::VALUE_W-1:0] coeffs_m [TAPS];
    int unsigned                         fill_m;
    logic [firs_pkg::CFG_W-1:0]          taps_m;
    firs_pkg::result_t                   filter_outputs_due [$];

    int mismatches;
    int burst_left;
    bit sender_gaps;
    bit rx_stalls;
    bit hold_request;

    fir_filter_stream_unit #(
        .MAX_TAPS(TAPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int unsigned effective_taps();
        int unsigned t;
        t = taps_m;
        if (t == 0)
        begin
            t = 1;
        end
        if (t > TAPS)
        begin
            t = TAPS;
        end
        return t;
    endfunction

    task automatic compute_filter_item(input firs_pkg::op_t op,
                                       input logic [firs_pkg::SLOT_W-1:0] slot,
                                       input logic signed [firs_pkg::VALUE_W-1:0] val,
                                       input logic eob);
        int unsigned       t;
        longint            acc;
        longint            q;
        firs_pkg::result_t r;
        t = effective_taps();
        if (op == firs_pkg::OP_LOAD)
        begin
            coeffs_m[slot] = val;
        end
        else
        begin
            for (int i = TAPS - 1; i > 0; i--)
            begin
                window_m[i] = window_m[i-1];
            end
            window_m[0] = val;
            if (fill_m < t)
            begin
                fill_m++;
            end
            if (fill_m >= t)
            begin
                acc = 0;
                for (int i = 0; i < t; i++)
                begin
                    acc += longint'(coeffs_m[i]) * longint'(window_m[t-1-i]);
                end
                q = acc >>> firs_pkg::FRAC_BITS;
                r.saturated = 1'b0;
                if (q > 32767)
                begin
                    q = 32767;
                    r.saturated = 1'b1;
                end
                else if (q < -32768)
                begin
                    q = -32768;
                    r.saturated = 1'b1;
                end
                r.filtered_value = q[firs_pkg::VALUE_W-1:0];
                filter_outputs_due.push_back(r);
            end
            if (eob)
            begin
                fill_m = 0;
            end
        end
    endtask

    task automatic send_item(input firs_pkg::op_t op, input logic [firs_pkg::SLOT_W-1:0] slot,
                             input logic [firs_pkg::VALUE_W-1:0] val, input logic eob);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 8);
            end
        end
        burst_left--;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, slot};
        s_axis_tuser  <= op;
        s_axis_tlast  <= eob;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        compute_filter_item(op, slot, val, eob);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (filter_outputs_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_tap_count(input logic [firs_pkg::CFG_W-1:0] taps);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= taps;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        taps_m = taps;
    endtask

    function automatic logic [firs_pkg::VALUE_W-1:0] random_value(input int shift);
        logic signed [firs_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = firs_pkg::VALUE_MAX;
            1: v = firs_pkg::VALUE_MIN;
            2: v = '0;
            3: v = 16'($urandom_range(0, 31)) - 16'd16;
            default: v = $signed(16'($urandom)) >>> shift;
        endcase
        return v;
    endfunction

    // Output side: free running, a rotating stall mask, or one long hold-off.
    initial
    begin : receiver
        int hold_left;
        int cnt;
        logic [15:0] mask;
        hold_left = 0;
        cnt = 0;
        mask = 16'hFFFF;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (cnt % 64 == 0)
            begin
                mask = 16'($urandom) | 16'h0001;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_stalls)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= mask[cnt % 16];
            end
            cnt++;
        end
    end

    always @(posedge clk)
    begin : output_check
        firs_pkg::result_t got;
        firs_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.filtered_value = m_axis_tdata;
            got.saturated      = m_axis_tuser[0];
            if (filter_outputs_due.size() == 0)
            begin
                $display("%0t: unexpected output: value %0d saturated %0b", $time,
                         got.filtered_value, got.saturated);
                mismatches++;
            end
            else
            begin
                want = filter_outputs_due.pop_front();
                if (got.filtered_value !== want.filtered_value)
                begin
                    $display("%0t: filtered_value expected %0d actual %0d", $time,
                             want.filtered_value, got.filtered_value);
                    mismatches++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.saturated, got.saturated);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h1234, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h8001, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h0001, 1'b1);
    endtask

    task automatic test_single_tap_extremes();
        set_tap_count(6'd0);
        send_item(firs_pkg::OP_LOAD, 5'd0, firs_pkg::VALUE_MIN, 1'b1);
        send_item(firs_pkg::OP_PUSH, 5'd0, firs_pkg::VALUE_MIN, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, firs_pkg::VALUE_MAX, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h0000, 1'b1);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h0001, 1'b0);
    endtask

    task automatic test_saturation_and_blocks();
        set_tap_count(6'd2);
        send_item(firs_pkg::OP_LOAD, 5'd1, firs_pkg::VALUE_MIN, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd31, firs_pkg::VALUE_MAX, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, firs_pkg::VALUE_MAX, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'hFFFF, 1'b1);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'd5, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'd7, 1'b0);
        send_item(firs_pkg::OP_LOAD, 5'd31, firs_pkg::VALUE_MAX, 1'b1);
    endtask

    task automatic test_tap_change_mid_block();
        set_tap_count(6'd5);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h5555, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'hAAAA, 1'b0);
        set_tap_count(6'd1);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h4000, 1'b0);
        set_tap_count(6'd4);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'hC000, 1'b0);
        send_item(firs_pkg::OP_PUSH, 5'd0, 16'h0100, 1'b1);
    endtask

    task automatic run_filter_phase(input logic [firs_pkg::CFG_W-1:0] taps, input int n_items);
        int t_eff;
        int sent;
        int block_len;
        int shift;
        set_tap_count(taps);
        t_eff = effective_taps();
        shift = $urandom_range(0, 6);
        if ($urandom_range(0, 1))
        begin
            for (int s = 0; s < TAPS; s++)
            begin
                send_item(firs_pkg::OP_LOAD, 5'(s), random_value(shift),
                          1'($urandom_range(0, 1)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_item(firs_pkg::OP_LOAD, 5'($urandom), random_value(shift),
                          1'($urandom_range(0, 1)));
            end
        end
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                block_len = $urandom_range(1, t_eff);
            end
            else
            begin
                block_len = $urandom_range(t_eff, t_eff + 24);
            end
            for (int k = 0; k < block_len; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_item(firs_pkg::OP_LOAD, 5'($urandom), random_value(shift),
                              1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 149) == 0)
                begin
                    wait_for_drain();
                end
                send_item(firs_pkg::OP_PUSH, 5'($urandom), random_value(0),
                          1'(k == block_len - 1 || $urandom_range(0, 99) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_random_settings();
        logic [firs_pkg::CFG_W-1:0] choices [12];
        choices = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd16, 6'd31, 6'd32,
                    6'd0, 6'd33, 6'd63, 6'd40};
        for (int p = 0; p < 16; p++)
        begin
            sender_gaps = (p % 3 != 0);
            rx_stalls   = (p % 4 != 1);
            if (p < 12)
            begin
                run_filter_phase(choices[p], 120);
            end
            else
            begin
                run_filter_phase(6'($urandom_range(1, TAPS)), 120);
            end
        end
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b1;
        set_tap_count(6'd3);
        hold_request = 1'b1;
        for (int k = 0; k < 200; k++)
        begin
            send_item(firs_pkg::OP_PUSH, 5'($urandom), random_value(0), 1'(k % 50 == 49));
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = firs_pkg::OP_PUSH;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        sender_gaps   = 1'b1;
        rx_stalls     = 1'b1;
        burst_left    = 0;
        mismatches    = 0;
        fill_m        = 0;
        taps_m        = 6'(firs_pkg::TAP_RESET);
        for (int i = 0; i < TAPS; i++)
        begin
            window_m[i] = '0;
            coeffs_m[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_tap_extremes();
        test_saturation_and_blocks();
        test_tap_change_mid_block();
        test_random_settings();
        test_output_backpressure();

        wait_for_drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/firs_pkg.sv
hdl/fir_filter_stream_unit.sv
hdl/firs_checker.sv
tb/sv/testbench.sv
